>>> sv/vfm_pkg.sv
// ----------------------------------------------------------------------------
// vfm_pkg: shared types and constants of the voxel face mesher
// Actions, queue entry format, sequencer states and the face corner table.
// ----------------------------------------------------------------------------
package vfm_pkg;

  localparam int SideDef   = 32;
  localparam int HeightDef = 128;

  typedef enum logic [1:0] {
    ACT_WR_VOX = 2'd0,
    ACT_WR_BRD = 2'd1,
    ACT_CLR    = 2'd2,
    ACT_MESH   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } back_state_e;

  // one queued transaction, already range-checked
  typedef struct packed {
    action_e     act;
    logic [4:0]  x;
    logic [4:0]  y;
    logic [6:0]  z;
    logic        air;
    logic [31:0] rgba;
    logic [1:0]  side;
  } vfm_entry_t;

  typedef struct packed {
    logic       valid;
    vfm_entry_t entry;
  } vfm_head_t;

  // corner offsets {dx, dy, dz} per face and corner
  function automatic logic [2:0] vfm_corner(input logic [2:0] face, input logic [1:0] cn);
    logic [11:0] row;
    row = 12'b0;
    case (face)
      3'd0:    row = {3'b001, 3'b011, 3'b111, 3'b101};
      3'd1:    row = {3'b000, 3'b010, 3'b110, 3'b100};
      3'd2:    row = {3'b010, 3'b011, 3'b111, 3'b110};
      3'd3:    row = {3'b000, 3'b001, 3'b101, 3'b100};
      3'd4:    row = {3'b100, 3'b101, 3'b111, 3'b110};
      3'd5:    row = {3'b000, 3'b001, 3'b011, 3'b010};
      default: row = 12'b0;
    endcase
    case (cn)
      2'd0:    return row[11:9];
      2'd1:    return row[8:6];
      2'd2:    return row[5:3];
      default: return row[2:0];
    endcase
  endfunction

endpackage

>>> sv/vfm_front.sv
// ----------------------------------------------------------------------------
// vfm_front: command intake
// Takes commands, drops out-of-range ones and queues the rest for the back end.
// ----------------------------------------------------------------------------
module vfm_front import vfm_pkg::*; #(
  parameter int SIDE   = SideDef,
  parameter int HEIGHT = HeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [4:0]  voxel_x_i,
  input  logic [4:0]  voxel_y_i,
  input  logic [6:0]  voxel_z_i,
  input  logic        is_air_i,
  input  logic [31:0] voxel_rgba_i,
  input  logic [1:0]  border_side_i,
  input  logic        pop_i,
  output vfm_head_t   head_o
);

  vfm_entry_t fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       accept, keep, push;
  logic [4:0] along;
  vfm_entry_t ent;

  assign busy   = (cnt_q == 2'd2);
  assign accept = start && !busy;

  always_comb begin
    ent.act  = action_e'(action_i);
    ent.x    = voxel_x_i;
    ent.y    = voxel_y_i;
    ent.z    = voxel_z_i;
    ent.air  = is_air_i;
    ent.rgba = voxel_rgba_i;
    ent.side = border_side_i;
    along    = border_side_i[1] ? voxel_y_i : voxel_x_i;
    case (ent.act)
      ACT_CLR:    keep = 1'b1;
      ACT_WR_BRD: keep = (int'(along) < SIDE) && (int'(voxel_z_i) < HEIGHT);
      default:    keep = (int'(voxel_x_i) < SIDE) && (int'(voxel_y_i) < SIDE) &&
                         (int'(voxel_z_i) < HEIGHT);
    endcase
  end

  assign push = accept && keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= ent;
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.entry = fifo_q[rd_ptr_q];

endmodule

>>> sv/vfm_back.sv
// ----------------------------------------------------------------------------
// vfm_back: voxel store and face emitter
// Performs writes, reads the seven cells around a voxel, emits face vertices.
// ----------------------------------------------------------------------------
module vfm_back import vfm_pkg::*; #(
  parameter int SIDE   = SideDef,
  parameter int HEIGHT = HeightDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  vfm_head_t    head_i,
  output logic         pop_o,
  input  logic [15:0]  chunk_x_i,
  input  logic [15:0]  chunk_y_i,
  output logic         result_valid_o,
  output logic [21:0]  pos_x_o,
  output logic [21:0]  pos_y_o,
  output logic [7:0]   pos_z_o,
  output logic [2:0]   face_dir_o,
  output logic [31:0]  vertex_rgba_o,
  output logic [21:0]  vertex_index_o,
  output logic         last_vertex_o
);

  localparam int Plane = SIDE * HEIGHT;
  localparam int Vol   = SIDE * Plane;
  localparam int Va    = $clog2(Vol);
  localparam int Ba    = $clog2(4 * Plane);

  logic        air_mem [Vol];
  logic [31:0] col_mem [Vol];
  logic        brd_mem [4 * Plane];

  back_state_e state_q, state_d;
  vfm_entry_t  cur_q, cur_d;
  logic [Va-1:0] vaddr_q, vaddr_d;
  logic [Ba-1:0] xa_q, xa_d, ya_q, ya_d;
  logic [2:0]  step_q, step_d;
  logic        pend_q, pend_d, pend_ok_q, pend_sel_q;
  logic [2:0]  pend_step_q;
  logic [5:0]  mask_q, mask_d;
  logic        cen_air_q, cen_air_d;
  logic [31:0] color_q, color_d;
  logic [1:0]  corner_q, corner_d;
  logic [21:0] cnt_q, cnt_d;

  logic        vox_we, brd_we;
  logic [Va-1:0] wr_vaddr, rd_vaddr;
  logic [Ba-1:0] wr_baddr, rd_baddr;
  logic        rd_ok, rd_sel, issue;
  logic        air_rd_q, brd_rd_q;
  logic [31:0] col_rd_q;
  logic        nb_air;

  logic        emit;
  logic [2:0]  face, dxyz;
  logic [21:0] ox, oy;

  // ---- storage ----
  always_ff @(posedge clk_i) begin
    if (vox_we) begin
      air_mem[wr_vaddr] <= head_i.entry.air;
      col_mem[wr_vaddr] <= head_i.entry.rgba;
    end
    air_rd_q <= air_mem[rd_vaddr];
    col_rd_q <= col_mem[rd_vaddr];
  end

  always_ff @(posedge clk_i) begin
    if (brd_we) brd_mem[wr_baddr] <= head_i.entry.air;
    brd_rd_q <= brd_mem[rd_baddr];
  end

  // write addresses straight from the queue head
  always_comb begin
    logic [4:0] along;
    along    = head_i.entry.side[1] ? head_i.entry.y : head_i.entry.x;
    wr_vaddr = Va'((int'(head_i.entry.x) * SIDE + int'(head_i.entry.y)) * HEIGHT +
                   int'(head_i.entry.z));
    wr_baddr = Ba'(int'(head_i.entry.side) * Plane + int'(along) * HEIGHT +
                   int'(head_i.entry.z));
  end

  // neighbour read for the current step: centre, +z, -z, +y, -y, +x, -x
  always_comb begin
    rd_vaddr = vaddr_q;
    rd_baddr = xa_q;
    rd_ok    = 1'b1;
    rd_sel   = 1'b0;
    case (step_q)
      3'd1: begin
        rd_vaddr = vaddr_q + Va'(1);
        rd_ok    = (int'(cur_q.z) + 1 < HEIGHT);
      end
      3'd2: begin
        rd_vaddr = vaddr_q - Va'(1);
        rd_ok    = (cur_q.z != 7'd0);
      end
      3'd3: begin
        rd_vaddr = vaddr_q + Va'(HEIGHT);
        rd_sel   = (int'(cur_q.y) == SIDE - 1);
        rd_baddr = xa_q;
      end
      3'd4: begin
        rd_vaddr = vaddr_q - Va'(HEIGHT);
        rd_sel   = (cur_q.y == 5'd0);
        rd_baddr = xa_q + Ba'(Plane);
      end
      3'd5: begin
        rd_vaddr = vaddr_q + Va'(Plane);
        rd_sel   = (int'(cur_q.x) == SIDE - 1);
        rd_baddr = ya_q + Ba'(2 * Plane);
      end
      3'd6: begin
        rd_vaddr = vaddr_q - Va'(Plane);
        rd_sel   = (cur_q.x == 5'd0);
        rd_baddr = ya_q + Ba'(3 * Plane);
      end
      default: ;
    endcase
  end

  assign nb_air = pend_ok_q && (pend_sel_q ? brd_rd_q : air_rd_q);

  // lowest face still to show
  always_comb begin
    face = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (mask_q[i]) face = 3'(i);
    end
  end

  assign dxyz = vfm_corner(face, corner_q);
  assign ox   = 22'($signed(chunk_x_i) * SIDE);
  assign oy   = 22'($signed(chunk_y_i) * SIDE);

  // ---- sequencer ----
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    vaddr_d   = vaddr_q;
    xa_d      = xa_q;
    ya_d      = ya_q;
    step_d    = step_q;
    pend_d    = 1'b0;
    mask_d    = mask_q;
    cen_air_d = cen_air_q;
    color_d   = color_q;
    corner_d  = corner_q;
    cnt_d     = cnt_q;
    pop_o     = 1'b0;
    vox_we    = 1'b0;
    brd_we    = 1'b0;
    issue     = 1'b0;
    emit      = 1'b0;

    if (pend_q) begin
      if (pend_step_q == 3'd0) begin
        cen_air_d = air_rd_q;
        color_d   = col_rd_q;
      end else begin
        mask_d[pend_step_q - 3'd1] = nb_air;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          case (head_i.entry.act)
            ACT_WR_VOX: vox_we = 1'b1;
            ACT_WR_BRD: brd_we = 1'b1;
            ACT_CLR:    cnt_d  = '0;
            default: begin
              cur_d    = head_i.entry;
              vaddr_d  = wr_vaddr;
              xa_d     = Ba'(int'(head_i.entry.x) * HEIGHT + int'(head_i.entry.z));
              ya_d     = Ba'(int'(head_i.entry.y) * HEIGHT + int'(head_i.entry.z));
              step_d   = 3'd0;
              corner_d = 2'd0;
              state_d  = ST_READ;
            end
          endcase
        end
      end
      ST_READ: begin
        if (step_q == 3'd7) begin
          state_d = ST_EMIT;
        end else begin
          issue  = 1'b1;
          pend_d = 1'b1;
          step_d = step_q + 3'd1;
        end
      end
      ST_EMIT: begin
        if (cen_air_q || mask_q == 6'd0) begin
          state_d = ST_IDLE;
        end else begin
          emit     = 1'b1;
          cnt_d    = cnt_q + 22'd1;
          corner_d = corner_q + 2'd1;
          if (corner_q == 2'd3) begin
            mask_d[face] = 1'b0;
            if ((mask_q & ~(6'd1 << face)) == 6'd0) state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q          <= '0;
      pend_q         <= 1'b0;
      step_q         <= 3'd0;
      mask_q         <= '0;
      cen_air_q      <= 1'b1;
      corner_q       <= 2'd0;
      result_valid_o <= 1'b0;
    end else begin
      cnt_q          <= cnt_d;
      pend_q         <= pend_d;
      step_q         <= step_d;
      mask_q         <= mask_d;
      cen_air_q      <= cen_air_d;
      corner_q       <= corner_d;
      result_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    vaddr_q <= vaddr_d;
    xa_q    <= xa_d;
    ya_q    <= ya_d;
    color_q <= color_d;
    if (issue) begin
      pend_ok_q   <= rd_ok;
      pend_sel_q  <= rd_sel;
      pend_step_q <= step_q;
    end
    if (emit) begin
      pos_x_o        <= ox + 22'(cur_q.x) + 22'(dxyz[2]);
      pos_y_o        <= oy + 22'(cur_q.y) + 22'(dxyz[1]);
      pos_z_o        <= 8'(cur_q.z) + 8'(dxyz[0]);
      face_dir_o     <= face;
      vertex_rgba_o  <= color_q;
      vertex_index_o <= cnt_q;
      last_vertex_o  <= (corner_q == 2'd3) && ((mask_q & ~(6'd1 << face)) == 6'd0);
    end
  end

endmodule

>>> sv/voxel_face_mesher.sv
// Sequence: a mesh transaction's vertices follow the queue, the READ steps and EMIT,
//   one vertex a cycle, up to 24; writes and clears are done in the idle state once
//   at the queue head.
// Throughput: one transaction at a time in the back end; a mesh holds it through
//   the centre and six neighbour reads, then one vertex a cycle.
// Results strobed one cycle, receiver cannot stall; reset clears control and counter.
// ----------------------------------------------------------------------------
// voxel_face_mesher: culled-face mesher for one voxel chunk
// Front end queues commands; back end stores voxels and emits face vertices.
// ----------------------------------------------------------------------------
module voxel_face_mesher import vfm_pkg::*; #(
  parameter int SIDE   = SideDef,
  parameter int HEIGHT = HeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command transaction
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [4:0]  voxel_x_i,
  input  logic [4:0]  voxel_y_i,
  input  logic [6:0]  voxel_z_i,
  input  logic        is_air_i,
  input  logic [31:0] voxel_rgba_i,
  input  logic [1:0]  border_side_i,
  // register writes
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // vertex transactions
  output logic        result_valid_o,
  output logic [21:0] pos_x_o,
  output logic [21:0] pos_y_o,
  output logic [7:0]  pos_z_o,
  output logic [2:0]  face_dir_o,
  output logic [31:0] vertex_rgba_o,
  output logic [21:0] vertex_index_o,
  output logic        last_vertex_o
);

  localparam logic RegChunkX = 1'b0;

  logic [15:0] chunk_x_q, chunk_y_q;
  vfm_head_t   head;
  logic        pop;

  // chunk coordinates; the user writes them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_x_q <= '0;
      chunk_y_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegChunkX) chunk_x_q <= cfg_data_i;
      else chunk_y_q <= cfg_data_i;
    end
  end

  vfm_front #(.SIDE(SIDE), .HEIGHT(HEIGHT)) u_front (
    .clk_i, .rst_ni, .start, .busy,
    .action_i, .voxel_x_i, .voxel_y_i, .voxel_z_i, .is_air_i, .voxel_rgba_i,
    .border_side_i,
    .pop_i  (pop),
    .head_o (head)
  );

  // back end: seven reads (centre and six neighbours), then 4 vertices a face
  vfm_back #(.SIDE(SIDE), .HEIGHT(HEIGHT)) u_back (
    .clk_i, .rst_ni,
    .head_i    (head),
    .pop_o     (pop),
    .chunk_x_i (chunk_x_q),
    .chunk_y_i (chunk_y_q),
    .result_valid_o, .pos_x_o, .pos_y_o, .pos_z_o, .face_dir_o,
    .vertex_rgba_o, .vertex_index_o, .last_vertex_o
  );

endmodule

>>> sv/vfm_checker.sv
// ----------------------------------------------------------------------------
// vfm_checker: port-level checks of the voxel face mesher
// Watches the vertex stream for ordering and range slips.
// ----------------------------------------------------------------------------
module vfm_checker import vfm_pkg::*; #(
  parameter int HEIGHT = HeightDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        result_valid_o,
  input logic [7:0]  pos_z_o,
  input logic [2:0]  face_dir_o,
  input logic [21:0] vertex_index_o,
  input logic        last_vertex_o
);

  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (face_dir_o <= 3'd5))
    else $error("face code out of range");

  a_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (int'(pos_z_o) <= HEIGHT))
    else $error("vertex height beyond chunk");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_vertex_o |=> result_valid_o)
    else $error("vertex burst broken");

  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_vertex_o |=>
      vertex_index_o == $past(vertex_index_o) + 22'd1)
    else $error("vertex index not consecutive");

endmodule

bind voxel_face_mesher vfm_checker #(.HEIGHT(HEIGHT)) u_vfm_checker (
  .clk_i, .rst_ni, .result_valid_o, .pos_z_o, .face_dir_o, .vertex_index_o,
  .last_vertex_o
);

>>> tb/vfm_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vfm_tb_pkg: shared codes of the voxel face mesher testbench
// Register indexes, face directions and border planes used by stimulus and checker.
// ----------------------------------------------------------------------------
package vfm_tb_pkg;

  localparam logic REG_CHUNK_X = 1'b0;
  localparam logic REG_CHUNK_Y = 1'b1;

  typedef enum logic [2:0] {
    FACE_PZ = 3'd0,
    FACE_NZ = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PX = 3'd4,
    FACE_NX = 3'd5
  } face_e;

  typedef enum logic [1:0] {
    PLANE_PY = 2'd0,
    PLANE_NY = 2'd1,
    PLANE_PX = 2'd2,
    PLANE_NX = 2'd3
  } plane_e;

endpackage

>>> tb/vfm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vfm_scoreboard: vertex predictor and scoreboard for the voxel face mesher
// Mirrors stores and registers from accepted transactions, compares vertices.
// ----------------------------------------------------------------------------
module vfm_scoreboard import vfm_pkg::*; import vfm_tb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  action_i,
  input  logic [4:0]  voxel_x_i,
  input  logic [4:0]  voxel_y_i,
  input  logic [6:0]  voxel_z_i,
  input  logic        is_air_i,
  input  logic [31:0] voxel_rgba_i,
  input  logic [1:0]  border_side_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        result_valid_o,
  input  logic [21:0] pos_x_o,
  input  logic [21:0] pos_y_o,
  input  logic [7:0]  pos_z_o,
  input  logic [2:0]  face_dir_o,
  input  logic [31:0] vertex_rgba_o,
  input  logic [21:0] vertex_index_o,
  input  logic        last_vertex_o,
  output int          pending_o,
  output int          fails_o
);

  typedef struct {
    logic [21:0] px;
    logic [21:0] py;
    logic [7:0]  pz;
    logic [2:0]  face;
    logic [31:0] rgba;
    logic [21:0] idx;
    logic        last;
  } vertex_t;

  bit          air_map [131072];
  logic [31:0] colour_map [131072];
  bit          plane_air [16384];
  logic [21:0] vtx_count;
  logic [15:0] chunk_x, chunk_y;
  vertex_t     vertex_q [$];

  function automatic bit air_of(logic [4:0] x, logic [4:0] y, logic [6:0] z);
    return air_map[{x, y, z}];
  endfunction

  // expand one mesh command into its face vertices
  task automatic mesh_voxel(logic [4:0] x, logic [4:0] y, logic [6:0] z);
    bit          shown [6];
    logic [21:0] ox, oy;
    logic        a, b;
    logic [2:0]  d;
    vertex_t     v;
    int          n;
    n = 0;
    if (air_of(x, y, z)) return;
    shown[FACE_PZ] = (z != 7'd127) && air_of(x, y, z + 7'd1);
    shown[FACE_NZ] = (z != 7'd0) && air_of(x, y, z - 7'd1);
    shown[FACE_PY] = (y != 5'd31) ? air_of(x, y + 5'd1, z) : plane_air[{PLANE_PY, x, z}];
    shown[FACE_NY] = (y != 5'd0) ? air_of(x, y - 5'd1, z) : plane_air[{PLANE_NY, x, z}];
    shown[FACE_PX] = (x != 5'd31) ? air_of(x + 5'd1, y, z) : plane_air[{PLANE_PX, y, z}];
    shown[FACE_NX] = (x != 5'd0) ? air_of(x - 5'd1, y, z) : plane_air[{PLANE_NX, y, z}];
    ox = {chunk_x[15], chunk_x, 5'b0};
    oy = {chunk_y[15], chunk_y, 5'b0};
    for (int f = 0; f < 6; f++) begin
      if (!shown[f]) continue;
      for (int c = 0; c < 4; c++) begin
        // corner walk on the face plane: (0,0) (0,1) (1,1) (1,0)
        a = (c == 2) || (c == 3);
        b = (c == 1) || (c == 2);
        case (f)
          FACE_PZ, FACE_NZ: d = {a, b, f == FACE_PZ};
          FACE_PY, FACE_NY: d = {a, f == FACE_PY, b};
          default:          d = {f == FACE_PX, a, b};
        endcase
        v.px   = ox + 22'(x) + 22'(d[2]);
        v.py   = oy + 22'(y) + 22'(d[1]);
        v.pz   = 8'(z) + 8'(d[0]);
        v.face = 3'(f);
        v.rgba = colour_map[{x, y, z}];
        v.idx  = vtx_count;
        v.last = 1'b0;
        vtx_count = vtx_count + 22'd1;
        vertex_q = {vertex_q, v};
        n++;
      end
    end
    if (n > 0) vertex_q[$].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t e;
    if (!rst_ni) begin
      vtx_count = '0;
      chunk_x   = '0;
      chunk_y   = '0;
      fails_o   = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_CHUNK_X) chunk_x = cfg_data_i;
        else chunk_y = cfg_data_i;
      end
      // results before new commands: a vertex leaving now was predicted earlier
      if (result_valid_o) begin
        if (vertex_q.size() == 0) begin
          $error("vertex with none expected (index %0d)", vertex_index_o);
          fails_o++;
        end else begin
          e = vertex_q.pop_front();
          if (pos_x_o !== e.px) begin
            $error("pos_x: expected %h, got %h", e.px, pos_x_o); fails_o++;
          end
          if (pos_y_o !== e.py) begin
            $error("pos_y: expected %h, got %h", e.py, pos_y_o); fails_o++;
          end
          if (pos_z_o !== e.pz) begin
            $error("pos_z: expected %0d, got %0d", e.pz, pos_z_o); fails_o++;
          end
          if (face_dir_o !== e.face) begin
            $error("face_dir: expected %0d, got %0d", e.face, face_dir_o); fails_o++;
          end
          if (vertex_rgba_o !== e.rgba) begin
            $error("vertex_rgba: expected %h, got %h", e.rgba, vertex_rgba_o); fails_o++;
          end
          if (vertex_index_o !== e.idx) begin
            $error("vertex_index: expected %0d, got %0d", e.idx, vertex_index_o); fails_o++;
          end
          if (last_vertex_o !== e.last) begin
            $error("last_vertex: expected %0b, got %0b", e.last, last_vertex_o); fails_o++;
          end
        end
      end
      if (start && !busy) begin
        case (action_e'(action_i))
          ACT_WR_VOX: begin
            air_map[{voxel_x_i, voxel_y_i, voxel_z_i}]    = is_air_i;
            colour_map[{voxel_x_i, voxel_y_i, voxel_z_i}] = voxel_rgba_i;
          end
          ACT_WR_BRD: begin
            if (border_side_i == PLANE_PY || border_side_i == PLANE_NY)
              plane_air[{border_side_i, voxel_x_i, voxel_z_i}] = is_air_i;
            else
              plane_air[{border_side_i, voxel_y_i, voxel_z_i}] = is_air_i;
          end
          ACT_CLR:  vtx_count = '0;
          default:  mesh_voxel(voxel_x_i, voxel_y_i, voxel_z_i);
        endcase
      end
    end
    pending_o = vertex_q.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top of the voxel face mesher verification
// Drives command transactions and register writes, gives the verdict.
// ----------------------------------------------------------------------------
module testbench import vfm_pkg::*; import vfm_tb_pkg::*;;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action_i = ACT_CLR;
  logic [4:0]  voxel_x_i = '0;
  logic [4:0]  voxel_y_i = '0;
  logic [6:0]  voxel_z_i = '0;
  logic        is_air_i = 1'b0;
  logic [31:0] voxel_rgba_i = '0;
  logic [1:0]  border_side_i = PLANE_PY;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = REG_CHUNK_X;
  logic [15:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic [21:0] pos_x_o, pos_y_o, vertex_index_o;
  logic [7:0]  pos_z_o;
  logic [2:0]  face_dir_o;
  logic [31:0] vertex_rgba_o;
  logic        last_vertex_o;
  int          pending, fails;

  // stimulus side record of what has been written, so no unset entry is read
  bit vox_set [131072];
  bit plane_set [16384];
  bit calm = 1'b0;   // no idle gaps in the closing stretch
  int stall_cycles = 0;

  localparam int WatchdogLimit = 5000;

  always #4 clk_i = ~clk_i;

  voxel_face_mesher uut (.*);

  vfm_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .start, .busy, .action_i, .voxel_x_i, .voxel_y_i, .voxel_z_i,
    .is_air_i, .voxel_rgba_i, .border_side_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .result_valid_o, .pos_x_o, .pos_y_o, .pos_z_o, .face_dir_o, .vertex_rgba_o,
    .vertex_index_o, .last_vertex_o, .pending_o(pending), .fails_o(fails)
  );

  // watchdog: cycles without any transaction on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // one command transaction; called at a rising edge, returns at its accepting edge or after a random idle gap
  task automatic send(action_e act, logic [4:0] x, logic [4:0] y, logic [6:0] z,
                      logic air, logic [31:0] rgba, logic [1:0] side);
    start         <= 1'b1;
    action_i      <= act;
    voxel_x_i     <= x;
    voxel_y_i     <= y;
    voxel_z_i     <= z;
    is_air_i      <= air;
    voxel_rgba_i  <= rgba;
    border_side_i <= side;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic wr_vox(logic [4:0] x, logic [4:0] y, logic [6:0] z, logic air,
                        logic [31:0] rgba);
    vox_set[{x, y, z}] = 1'b1;
    send(ACT_WR_VOX, x, y, z, air, rgba, 2'($urandom));
  endtask

  // border flag; the unused coordinate is random since the block ignores it
  task automatic wr_plane(plane_e p, logic [4:0] along, logic [6:0] z, logic air);
    logic [4:0] other;
    other = 5'($urandom);
    plane_set[{p, along, z}] = 1'b1;
    if (p == PLANE_PY || p == PLANE_NY) send(ACT_WR_BRD, along, other, z, air, $urandom, p);
    else send(ACT_WR_BRD, other, along, z, air, $urandom, p);
  endtask

  task automatic fill_vox(logic [4:0] x, logic [4:0] y, logic [6:0] z);
    if (!vox_set[{x, y, z}]) wr_vox(x, y, z, 1'($urandom), $urandom);
  endtask

  task automatic fill_plane(plane_e p, logic [4:0] along, logic [6:0] z);
    if (!plane_set[{p, along, z}]) wr_plane(p, along, z, 1'($urandom));
  endtask

  // mesh after making sure all seven locations it reads hold written data
  task automatic mesh(logic [4:0] x, logic [4:0] y, logic [6:0] z);
    fill_vox(x, y, z);
    if (z != 7'd127) fill_vox(x, y, z + 7'd1);
    if (z != 7'd0) fill_vox(x, y, z - 7'd1);
    if (y != 5'd31) fill_vox(x, y + 5'd1, z); else fill_plane(PLANE_PY, x, z);
    if (y != 5'd0) fill_vox(x, y - 5'd1, z); else fill_plane(PLANE_NY, x, z);
    if (x != 5'd31) fill_vox(x + 5'd1, y, z); else fill_plane(PLANE_PX, y, z);
    if (x != 5'd0) fill_vox(x - 5'd1, y, z); else fill_plane(PLANE_NX, y, z);
    send(ACT_MESH, x, y, z, 1'($urandom), $urandom, 2'($urandom));
  endtask

  // coordinates biased towards the chunk edges so border planes get used
  function automatic logic [4:0] pick_xy();
    case ($urandom_range(0, 3))
      0:       return 5'($urandom_range(0, 2));
      1:       return 5'($urandom_range(29, 31));
      default: return 5'($urandom);
    endcase
  endfunction

  function automatic logic [6:0] pick_z();
    case ($urandom_range(0, 3))
      0:       return 7'($urandom_range(0, 2));
      1:       return 7'($urandom_range(125, 127));
      default: return 7'($urandom);
    endcase
  endfunction

  // register writes only once the block has drained
  task automatic set_chunk(logic [15:0] cx, logic [15:0] cy);
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (30) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_CHUNK_X;
    cfg_data_i <= cx;
    @(posedge clk_i);
    cfg_idx_i  <= REG_CHUNK_Y;
    cfg_data_i <= cy;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // each mesh brings its own neighbour writes, so one call sends several commands
  task automatic random_items(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 3) wr_vox(pick_xy(), pick_xy(), pick_z(), 1'($urandom), $urandom);
      else if (sel < 5) wr_plane(plane_e'($urandom_range(0, 3)), pick_xy(), pick_z(),
                                 1'($urandom));
      else if (sel == 5) send(ACT_CLR, 5'($urandom), 5'($urandom), 7'($urandom),
                              1'($urandom), $urandom, 2'($urandom));
      else mesh(pick_xy(), pick_xy(), pick_z());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corner voxel at the floor, all open neighbours -> no -z face
    wr_vox(5'd0, 5'd0, 7'd0, 1'b0, 32'hFFFF_FFFF);
    wr_vox(5'd0, 5'd0, 7'd1, 1'b1, 32'h0);
    wr_vox(5'd0, 5'd1, 7'd0, 1'b1, 32'h0);
    wr_vox(5'd1, 5'd0, 7'd0, 1'b1, 32'h0);
    wr_plane(PLANE_NY, 5'd0, 7'd0, 1'b1);
    wr_plane(PLANE_NX, 5'd0, 7'd0, 1'b1);
    mesh(5'd0, 5'd0, 7'd0);
    // opposite corner at the height limit -> no +z face, plus-side planes
    wr_vox(5'd31, 5'd31, 7'd127, 1'b0, 32'h0);
    wr_vox(5'd31, 5'd31, 7'd126, 1'b1, 32'h1234_5678);
    wr_vox(5'd31, 5'd30, 7'd127, 1'b1, 32'h0);
    wr_vox(5'd30, 5'd31, 7'd127, 1'b1, 32'h0);
    wr_plane(PLANE_PY, 5'd31, 7'd127, 1'b1);
    wr_plane(PLANE_PX, 5'd31, 7'd127, 1'b1);
    mesh(5'd31, 5'd31, 7'd127);
    // air voxel gives nothing; then a solid voxel with randomly filled neighbours
    mesh(5'd31, 5'd31, 7'd126);
    wr_vox(5'd10, 5'd10, 7'd60, 1'b0, 32'hA5A5_5A5A);
    mesh(5'd10, 5'd10, 7'd60);
    send(ACT_CLR, 5'd31, 5'd31, 7'd127, 1'b1, 32'hFFFF_FFFF, PLANE_NX);
    mesh(5'd0, 5'd0, 7'd0);

    random_items(15);
    set_chunk(16'h8000, 16'h7FFF);
    random_items(15);
    set_chunk(16'h7FFF, 16'h8000);
    random_items(15);
    set_chunk(16'($urandom), 16'($urandom));
    random_items(15);
    set_chunk(16'hFFFF, 16'h0001);
    calm = 1'b1;
    random_items(16);
    start <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
sv/vfm_pkg.sv
sv/vfm_front.sv
sv/vfm_back.sv
sv/voxel_face_mesher.sv
sv/vfm_checker.sv
tb/vfm_tb_pkg.sv
tb/vfm_checker.sv
tb/testbench.sv
